// File: hdl/btpt_pkg.sv
// shared constants, types and helpers for the branch target profile table
`default_nettype none

package btpt_pkg;

  localparam int unsigned UNITS        = 4;
  localparam int unsigned TARGET_SLOTS = 64;
  localparam int unsigned SOURCE_SLOTS = 8;
  localparam int unsigned COUNT_BITS   = 32;

  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned UNIT_W     = 2;
  localparam int unsigned STACK_W    = 5;
  localparam int unsigned UNIT_IDX_W = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int unsigned SLOT_W     = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
  localparam int unsigned SLOT_CW    = $clog2(TARGET_SLOTS + 1);
  localparam int unsigned SRC_W      = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
  localparam int unsigned LEN_W      = $clog2(SOURCE_SLOTS + 1);
  localparam int unsigned ROWS       = UNITS * TARGET_SLOTS;
  localparam int unsigned CELLS      = ROWS * SOURCE_SLOTS;
  localparam int unsigned ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CELL_W     = (CELLS > 1) ? $clog2(CELLS) : 1;

  typedef logic [COUNT_BITS-1:0] count_t;
  localparam count_t COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_BOTH_HIT     = 3'd0,
    ST_NEW_SOURCE   = 3'd1,
    ST_SOURCES_FULL = 3'd2,
    ST_NEW_TARGET   = 3'd3,
    ST_TABLE_FULL   = 3'd4,
    ST_IGNORED      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TSCAN,
    S_SSCAN
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  fault_addr;
    logic [STACK_W-1:0] stack_index;
    logic [LEN_W-1:0]   src_len;
    count_t             count;
    logic [ADDR_W-1:0]  target;
  } row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sig;
    count_t            count;
    logic [ADDR_W-1:0] addr;
  } cell_t;

  function automatic count_t sat_inc(count_t v);
    return (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

  function automatic logic [ROW_W-1:0] row_addr(logic [UNIT_IDX_W-1:0] u,
                                                logic [SLOT_W-1:0] s);
    return ROW_W'(u) * ROW_W'(TARGET_SLOTS) + ROW_W'(s);
  endfunction

  function automatic logic [CELL_W-1:0] cell_addr(logic [ROW_W-1:0] r,
                                                  logic [SRC_W-1:0] j);
    return CELL_W'(r) * CELL_W'(SOURCE_SLOTS) + CELL_W'(j);
  endfunction

endpackage

`default_nettype wire

// File: hdl/btpt_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module btpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/branch_target_profile_table.sv
// top level: scan sequencer over the target row memory and the source cell memory
`default_nettype none

// Each request (start high while busy is low) is looked up in its unit's target
// rows one slot per cycle, then in the matched target's sources one entry per
// cycle, since each memory has a single read port with a registered read.
// A zero target is answered in the cycle after start. The result shows for one
// cycle with done_o and cannot be held off; busy stays high until the memories
// are written back, so a new request never sees stale data. Target slots fill
// in order and are never freed, so a per-unit fill count marks the valid rows
// and no clearing pass is needed after reset.
module branch_target_profile_table
  import btpt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [UNIT_W-1:0]     unit_i,
  input  wire logic [ADDR_W-1:0]     target_addr_i,
  input  wire logic [ADDR_W-1:0]     source_addr_i,
  input  wire logic [STACK_W-1:0]    stack_index_i,
  input  wire logic [ADDR_W-1:0]     fault_addr_i,
  input  wire logic [ADDR_W-1:0]     signature_i,
  output logic                       done_o,
  output logic [2:0]                 status_o,
  output logic [5:0]                 target_slot_o,
  output logic [31:0]                target_hits_o,
  output logic [2:0]                 source_slot_o,
  output logic [31:0]                source_hits_o
);

  state_e state_q, state_d;

  logic [SLOT_CW-1:0]    cnt_q, cnt_d;
  logic                  chk_v_q, chk_v_d;
  logic [LEN_W-1:0]      scnt_q, scnt_d;
  logic                  schk_v_q, schk_v_d;
  logic [SLOT_W-1:0]     hit_slot_q, hit_slot_d;
  row_t                  row_q, row_d;
  count_t                th_q, th_d;
  logic [SLOT_CW-1:0]    fill_q [UNITS];
  logic [SLOT_CW-1:0]    fill_cur;
  logic                  fill_inc;

  logic [UNIT_IDX_W-1:0] unit_q;
  logic [ADDR_W-1:0]     to_q, from_q, fault_q, sig_q;
  logic [STACK_W-1:0]    tos_q;

  logic                  done_q, done_d;
  status_e               status_q, status_d;
  logic [SLOT_W-1:0]     tslot_q, tslot_d;
  count_t                th_out_q, th_out_d;
  logic [SRC_W-1:0]      sslot_q, sslot_d;
  count_t                sh_q, sh_d;

  logic                  accept;
  logic                  ignored;
  logic [SLOT_W-1:0]     chk_slot;
  logic [SRC_W-1:0]      schk_slot;
  logic [ROW_W-1:0]      hit_row;

  logic                  row_we, row_re;
  logic [ROW_W-1:0]      row_waddr, row_raddr;
  row_t                  row_wdata, row_rdata;
  logic                  cell_we, cell_re;
  logic [CELL_W-1:0]     cell_waddr, cell_raddr;
  cell_t                 cell_wdata, cell_rdata;

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign ignored   = (target_addr_i == '0) || (32'(unit_i) >= 32'(UNITS));
  assign fill_cur  = fill_q[unit_q];
  assign chk_slot  = SLOT_W'(cnt_q - SLOT_CW'(1));
  assign schk_slot = SRC_W'(scnt_q - LEN_W'(1));
  assign hit_row   = row_addr(unit_q, hit_slot_q);

  btpt_ram #(.WIDTH($bits(row_t)), .DEPTH(ROWS)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  btpt_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELLS)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (cell_re),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      chk_v_q  <= 1'b0;
      schk_v_q <= 1'b0;
      done_q   <= 1'b0;
      for (int u = 0; u < UNITS; u++) begin
        fill_q[u] <= '0;
      end
    end else begin
      state_q  <= state_d;
      chk_v_q  <= chk_v_d;
      schk_v_q <= schk_v_d;
      done_q   <= done_d;
      if (fill_inc) begin
        fill_q[unit_q] <= fill_cur + SLOT_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      unit_q  <= UNIT_IDX_W'(unit_i);
      to_q    <= target_addr_i;
      from_q  <= source_addr_i;
      tos_q   <= stack_index_i;
      fault_q <= fault_addr_i;
      sig_q   <= signature_i;
    end
    cnt_q      <= cnt_d;
    scnt_q     <= scnt_d;
    hit_slot_q <= hit_slot_d;
    row_q      <= row_d;
    th_q       <= th_d;
    status_q   <= status_d;
    tslot_q    <= tslot_d;
    th_out_q   <= th_out_d;
    sslot_q    <= sslot_d;
    sh_q       <= sh_d;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    chk_v_d    = chk_v_q;
    scnt_d     = scnt_q;
    schk_v_d   = schk_v_q;
    hit_slot_d = hit_slot_q;
    row_d      = row_q;
    th_d       = th_q;
    fill_inc   = 1'b0;
    done_d     = 1'b0;
    status_d   = status_q;
    tslot_d    = tslot_q;
    th_out_d   = th_out_q;
    sslot_d    = sslot_q;
    sh_d       = sh_q;
    row_we     = 1'b0;
    row_re     = 1'b0;
    row_waddr  = hit_row;
    row_raddr  = row_addr(unit_q, cnt_q[SLOT_W-1:0]);
    row_wdata  = row_q;
    cell_we    = 1'b0;
    cell_re    = 1'b0;
    cell_waddr = cell_addr(hit_row, schk_slot);
    cell_raddr = cell_addr(hit_row, scnt_q[SRC_W-1:0]);
    cell_wdata = cell_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (ignored) begin
            done_d   = 1'b1;
            status_d = ST_IGNORED;
            tslot_d  = '0;
            th_out_d = '0;
            sslot_d  = '0;
            sh_d     = '0;
          end else begin
            state_d = S_TSCAN;
            cnt_d   = '0;
            chk_v_d = 1'b0;
          end
        end
      end

      S_TSCAN: begin
        chk_v_d = 1'b0;
        if (chk_v_q && (row_rdata.target == to_q)) begin
          // target hit
          row_d      = row_rdata;
          hit_slot_d = chk_slot;
          th_d       = sat_inc(row_rdata.count);
          scnt_d     = '0;
          schk_v_d   = 1'b0;
          state_d    = S_SSCAN;
        end else if (cnt_q < fill_cur) begin
          row_re  = 1'b1;
          cnt_d   = cnt_q + SLOT_CW'(1);
          chk_v_d = 1'b1;
        end else if (fill_cur < SLOT_CW'(TARGET_SLOTS)) begin
          // insert new target at the first empty slot
          row_we                = 1'b1;
          row_waddr             = row_addr(unit_q, fill_cur[SLOT_W-1:0]);
          row_wdata.target      = to_q;
          row_wdata.count       = count_t'(1);
          row_wdata.src_len     = LEN_W'(1);
          row_wdata.stack_index = tos_q;
          row_wdata.fault_addr  = fault_q;
          cell_we               = 1'b1;
          cell_waddr            = cell_addr(row_addr(unit_q, fill_cur[SLOT_W-1:0]), '0);
          cell_wdata.addr       = from_q;
          cell_wdata.sig        = sig_q;
          cell_wdata.count      = count_t'(1);
          fill_inc              = 1'b1;
          done_d                = 1'b1;
          status_d              = ST_NEW_TARGET;
          tslot_d               = fill_cur[SLOT_W-1:0];
          th_out_d              = count_t'(1);
          sslot_d               = '0;
          sh_d                  = count_t'(1);
          state_d               = S_IDLE;
        end else begin
          done_d   = 1'b1;
          status_d = ST_TABLE_FULL;
          tslot_d  = '0;
          th_out_d = '0;
          sslot_d  = '0;
          sh_d     = '0;
          state_d  = S_IDLE;
        end
      end

      S_SSCAN: begin
        schk_v_d        = 1'b0;
        row_wdata.count = th_q;
        tslot_d         = hit_slot_q;
        th_out_d        = th_q;
        if (schk_v_q && (cell_rdata.addr == from_q)) begin
          // source hit
          row_we           = 1'b1;
          cell_we          = 1'b1;
          cell_wdata.count = sat_inc(cell_rdata.count);
          done_d           = 1'b1;
          status_d         = ST_BOTH_HIT;
          sslot_d          = schk_slot;
          sh_d             = sat_inc(cell_rdata.count);
          state_d          = S_IDLE;
        end else if (scnt_q < row_q.src_len) begin
          cell_re  = 1'b1;
          scnt_d   = scnt_q + LEN_W'(1);
          schk_v_d = 1'b1;
        end else if (row_q.src_len < LEN_W'(SOURCE_SLOTS)) begin
          // append source
          row_we            = 1'b1;
          row_wdata.src_len = row_q.src_len + LEN_W'(1);
          cell_we           = 1'b1;
          cell_waddr        = cell_addr(hit_row, row_q.src_len[SRC_W-1:0]);
          cell_wdata.addr   = from_q;
          cell_wdata.sig    = sig_q;
          cell_wdata.count  = count_t'(1);
          done_d            = 1'b1;
          status_d          = ST_NEW_SOURCE;
          sslot_d           = row_q.src_len[SRC_W-1:0];
          sh_d              = count_t'(1);
          state_d           = S_IDLE;
        end else begin
          row_we   = 1'b1;
          done_d   = 1'b1;
          status_d = ST_SOURCES_FULL;
          sslot_d  = '0;
          sh_d     = '0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign target_slot_o = 6'(tslot_q);
  assign target_hits_o = 32'(th_out_q);
  assign source_slot_o = 3'(sslot_q);
  assign source_hits_o = 32'(sh_q);

`ifndef SYNTH
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q != S_IDLE || accept))
    else $error("result without a request in flight");

  a_row_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(row_we && row_re))
    else $error("row memory read and written in one cycle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (fill_cur <= SLOT_CW'(TARGET_SLOTS)))
    else $error("fill count beyond table size");

  a_src_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SSCAN) |-> (scnt_q <= row_q.src_len &&
                              row_q.src_len <= LEN_W'(SOURCE_SLOTS)))
    else $error("source scan beyond list length");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ignored) |=> busy)
    else $error("lookup request did not start a scan");
`endif

endmodule

`default_nettype wire
